/* design/ptenc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptenc_pkg
// Shared types, widths and RSC lookahead functions for the turbo encoder.
// ----------------------------------------------------------------------------
package ptenc_pkg;

  localparam int ROW_W    = 32;  // info_row port width
  localparam int WORD_W   = 64;  // coded_word port width
  localparam int ROWNUM_W = 5;   // row_number port width

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take in_info_row, run first encoder
    logic emit;  // build one coded word, run second encoder over a column
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_last;   // row counter sits on the final row of the block
    logic out_free;  // output register can take a word this cycle
  } status_t;

  // Taps of the impulse response of 1/(1+D+D^2): period 1,1,0.
  function automatic logic [ROW_W-1:0] rsc_mask(input int t);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if ((i <= t) && (((t - i) % 3) != 2)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Feedback node sequence a[t] of the RSC over a vector of input bits.
  // st[0] is the newest delay element, st[1] the older one.
  function automatic logic [ROW_W-1:0] rsc_seq(input logic [1:0] st,
                                               input logic [ROW_W-1:0] bits);
    logic [ROW_W-1:0] a;
    logic             g;
    a = '0;
    for (int t = 0; t < ROW_W; t++) begin
      case (t % 3)
        0:       g = st[0] ^ st[1];
        1:       g = st[1];
        default: g = st[0];
      endcase
      a[t] = g ^ (^(bits & rsc_mask(t)));
    end
    return a;
  endfunction

  // Parity = a[t] xor a[t-2], with the start state standing in for t < 2.
  function automatic logic [ROW_W-1:0] rsc_par(input logic [1:0] st,
                                               input logic [ROW_W-1:0] a);
    logic [ROW_W-1:0] p;
    p[0] = a[0] ^ st[1];
    p[1] = a[1] ^ st[0];
    for (int t = 2; t < ROW_W; t++) begin
      p[t] = a[t] ^ a[t-2];
    end
    return p;
  endfunction

endpackage

/* design/ptenc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptenc_ctrl
// Block sequencer: loads rows, then emits the coded words of the block.
// ----------------------------------------------------------------------------
module ptenc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptenc_pkg::status_t  status,
  output ptenc_pkg::cmd_t     cmd
);
  import ptenc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && status.at_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.at_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

/* design/ptenc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptenc_dpath
// Row stores, both RSC encoders, row counter and the output register.
// ----------------------------------------------------------------------------
module ptenc_dpath #(
  parameter int SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptenc_pkg::cmd_t                     cmd,
  output ptenc_pkg::status_t                  status,
  input  logic [ptenc_pkg::ROW_W-1:0]         in_info_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ptenc_pkg::WORD_W-1:0]        out_coded_word,
  output logic [ptenc_pkg::ROWNUM_W-1:0]      out_row_number,
  output logic                                out_last
);
  import ptenc_pkg::*;

  localparam int   IDX_W    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam logic SIDE_ODD = ((SIDE % 2) == 1);

  logic [SIDE-1:0]     info_mem [SIDE];
  logic [SIDE-1:0]     par_mem  [SIDE];

  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_nxt;
  logic [1:0]          enc1_r;
  logic [1:0]          enc1_nxt;
  logic [1:0]          enc2_r;
  logic [1:0]          enc2_nxt;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [ROWNUM_W-1:0] out_row_r;
  logic                out_last_r;

  logic                at_last;
  logic [ROW_W-1:0]    a1;
  logic [ROW_W-1:0]    p1;
  logic [SIDE-1:0]     col;
  logic [ROW_W-1:0]    a2;
  logic [ROW_W-1:0]    p2;
  logic [SIDE-1:0]     info_sel;
  logic [SIDE-1:0]     par_sel;
  logic                row_odd;
  logic [WORD_W-1:0]   word;

  assign at_last         = (idx_r == IDX_W'(SIDE - 1));
  assign status.at_last  = at_last;
  assign status.out_free = !out_valid_r || out_ready;

  assign idx_nxt = at_last ? '0 : idx_r + 1'b1;

  // first encoder, one whole row per cycle while rows are loaded
  assign a1       = rsc_seq(enc1_r, ROW_W'(in_info_row[SIDE-1:0]));
  assign p1       = rsc_par(enc1_r, a1);
  assign enc1_nxt = at_last ? 2'b00 : {a1[SIDE-2], a1[SIDE-1]};

  // second encoder, one column (interleaved order) per cycle while the output is free
  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      col[i] = info_mem[i][idx_r];
    end
  end

  assign a2       = rsc_seq(enc2_r, ROW_W'(col));
  assign p2       = rsc_par(enc2_r, a2);
  assign enc2_nxt = at_last ? 2'b00 : {a2[SIDE-2], a2[SIDE-1]};

  // puncturing: even bits carry info, odd bits alternate parity1/parity2
  // on the parity of the flat info index row*SIDE + j
  assign info_sel = info_mem[idx_r];
  assign par_sel  = par_mem[idx_r];
  assign row_odd  = idx_r[0] & SIDE_ODD;

  always_comb begin
    word = '0;
    for (int j = 0; j < SIDE; j++) begin
      word[2*j] = info_sel[j];
      if (row_odd ^ ((j % 2) == 1)) begin
        word[2*j+1] = p2[j];
      end else begin
        word[2*j+1] = par_sel[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      info_mem[idx_r] <= in_info_row[SIDE-1:0];
      par_mem[idx_r]  <= p1[SIDE-1:0];
    end
    if (cmd.emit) begin
      out_word_r <= word;
      out_row_r  <= ROWNUM_W'(idx_r);
      out_last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      enc1_r      <= 2'b00;
      enc2_r      <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.emit) begin
        idx_r <= idx_nxt;
      end
      if (cmd.load) begin
        enc1_r <= enc1_nxt;
      end
      if (cmd.emit) begin
        enc2_r      <= enc2_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coded_word = out_word_r;
  assign out_row_number = out_row_r;
  assign out_last       = out_last_r;

endmodule

/* design/punctured_turbo_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctured_turbo_encoder
// Rate 1/2 punctured turbo encoder, two RSC (1+D+D^2 feedback) encoders
// around a SIDE x SIDE row/column block interleaver.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_info_row (32b)
//   out_     output     out_valid / out_ready  out_coded_word (64b),
//                                              out_row_number (5b), out_last
//
// Flow: one row transaction per cycle while a block loads, then one coded
//   word per cycle while out_ready allows; a block of SIDE rows is loaded
//   whole before any word is emitted. Both encoders use a one-row
//   lookahead so each row or column is encoded in one step.
// Reset: rst_n synchronous, active low; clears the sequencer, row counter,
//   encoder states and output valid. Row stores need no clearing.
// Stalls: out_ready low holds the output register and pauses emission; the
//   next block can start loading while the last word still waits.
// ----------------------------------------------------------------------------
module punctured_turbo_encoder #(
  parameter int SIDE = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptenc_pkg::ROW_W-1:0]        in_info_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptenc_pkg::WORD_W-1:0]       out_coded_word,
  output logic [ptenc_pkg::ROWNUM_W-1:0]     out_row_number,
  output logic                               out_last
);
  import ptenc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: LOAD accepts rows, EMIT drains the block word by word.
  ptenc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores, encoders, puncturing and output register.
  ptenc_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_info_row    (in_info_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_coded_word (out_coded_word),
    .out_row_number (out_row_number),
    .out_last       (out_last)
  );

  // last flag marks exactly the final row of the block
  a_last_row : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row_number == ROWNUM_W'(SIDE - 1))))
    else $error("out_last does not match row number");

  // final row transaction of a block closes the input
  a_load_to_emit : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.at_last) |=> !in_ready)
    else $error("input still open after last row");

  // final coded word reopens the input
  a_emit_to_load : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.at_last) |=> (in_ready && out_valid && out_last))
    else $error("block end did not return to loading");

endmodule
